// File: design/tpt_pkg.sv
// Shared types and constants of the two-level page table engine.
package tpt_pkg;

  localparam int DEF_NUM_SPACES = 4;
  localparam int DEF_NUM_TABLES = 16;
  localparam int IDX_W          = 10;
  localparam int OFS_W          = 12;
  localparam int ADDR_W         = 32;
  localparam int FRAME_W        = ADDR_W - OFS_W;

  typedef enum logic [1:0] {
    OP_MAP   = 2'd0,
    OP_UNMAP = 2'd1,
    OP_TRANS = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_TABLE   = 2'd1,
    STAT_NOT_MAPPED = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_DIR   = 5'b00100,
    ST_TBL   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  typedef struct packed {
    logic en;
    logic we;
  } mem_ctl_t;

endpackage

// File: design/tpt_ram.sv
// Single-port synchronous RAM with registered read data.
module tpt_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  tpt_pkg::mem_ctl_t ctl_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      if (ctl_i.we) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/tpt_ctrl.sv
// Request sequencer: clearing sweep, directory lookup, table access, result register.
module tpt_ctrl #(
  parameter int NUM_SPACES = tpt_pkg::DEF_NUM_SPACES,
  parameter int NUM_TABLES = tpt_pkg::DEF_NUM_TABLES,
  parameter int TW         = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1,
  parameter int DAW        = $clog2(NUM_SPACES * 1024),
  parameter int TAW        = TW + tpt_pkg::IDX_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        opcode_i,
  input  logic [1:0]        space_i,
  input  logic [31:0]       virt_addr_i,
  input  logic [31:0]       phys_addr_i,
  input  logic [11:0]       page_flags_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [31:0]       phys_out_o,
  output tpt_pkg::mem_ctl_t dir_ctl_o,
  output logic [DAW-1:0]    dir_addr_o,
  output logic [TW:0]       dir_wdata_o,
  input  logic [TW:0]       dir_rdata_i,
  output tpt_pkg::mem_ctl_t tbl_ctl_o,
  output logic [TAW-1:0]    tbl_addr_o,
  output logic [31:0]       tbl_wdata_o,
  input  logic [31:0]       tbl_rdata_i
);

  localparam int DIR_DEPTH = NUM_SPACES * 1024;
  localparam int TBL_DEPTH = NUM_TABLES * 1024;
  localparam int CLR_DEPTH = (DIR_DEPTH > TBL_DEPTH) ? DIR_DEPTH : TBL_DEPTH;
  localparam int CW        = $clog2(CLR_DEPTH);
  localparam int UW        = $clog2(NUM_TABLES + 1);
  localparam logic [CW:0]   DIR_LIM  = (CW + 1)'(DIR_DEPTH);
  localparam logic [CW:0]   TBL_LIM  = (CW + 1)'(TBL_DEPTH);
  localparam logic [CW-1:0] CLR_LAST = CW'(CLR_DEPTH - 1);
  localparam logic [UW-1:0] USED_MAX = UW'(NUM_TABLES);

  tpt_pkg::state_e state_q, state_d;
  logic [CW-1:0]   clr_q, clr_d;
  logic [UW-1:0]   used_q, used_d;

  logic [1:0]                 op_q;
  logic                       sp_ok_q;
  logic [DAW-1:0]             dslot_q;
  logic [tpt_pkg::IDX_W-1:0]  ti_q;
  logic [tpt_pkg::OFS_W-1:0]  ofs_q;
  logic [31:0]                entry_q;

  logic [1:0]  res_status_q, res_status_d;
  logic [31:0] res_phys_q, res_phys_d;
  logic        out_valid_q, out_valid_d;
  logic [1:0]  out_status_q, out_status_d;
  logic [31:0] out_phys_q, out_phys_d;

  logic           accept;
  logic           take;
  logic           present;
  logic [TW-1:0]  tnum;
  logic [DAW-1:0] in_dslot;

  assign accept   = in_valid_i && !in_stall_o;
  assign take     = out_valid_q && !out_stall_i;
  assign in_dslot = DAW'({space_i, virt_addr_i[31:22]});
  assign present  = sp_ok_q && dir_rdata_i[TW];
  assign tnum     = dir_rdata_i[TW-1:0];

  assign in_stall_o  = (state_q != tpt_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign phys_out_o  = out_phys_q;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    used_d       = used_q;
    res_status_d = res_status_q;
    res_phys_d   = res_phys_q;
    out_valid_d  = out_valid_q && !take;
    out_status_d = out_status_q;
    out_phys_d   = out_phys_q;
    dir_ctl_o    = '0;
    dir_addr_o   = dslot_q;
    dir_wdata_o  = '0;
    tbl_ctl_o    = '0;
    tbl_addr_o   = {tnum, ti_q};
    tbl_wdata_o  = '0;

    unique case (state_q)
      tpt_pkg::ST_CLEAR: begin
        dir_ctl_o.en = ({1'b0, clr_q} < DIR_LIM);
        dir_ctl_o.we = 1'b1;
        dir_addr_o   = clr_q[DAW-1:0];
        tbl_ctl_o.en = ({1'b0, clr_q} < TBL_LIM);
        tbl_ctl_o.we = 1'b1;
        tbl_addr_o   = TAW'(clr_q);
        clr_d        = clr_q + CW'(1);
        if (clr_q == CLR_LAST) begin
          state_d = tpt_pkg::ST_IDLE;
        end
      end
      tpt_pkg::ST_IDLE: begin
        dir_addr_o = in_dslot;
        if (accept) begin
          dir_ctl_o.en = 1'b1;
          state_d      = tpt_pkg::ST_DIR;
        end
      end
      tpt_pkg::ST_DIR: begin
        res_status_d = tpt_pkg::STAT_OK;
        res_phys_d   = '0;
        state_d      = tpt_pkg::ST_DONE;
        case (tpt_pkg::opcode_e'(op_q))
          tpt_pkg::OP_MAP: begin
            tbl_wdata_o = entry_q;
            if (present) begin
              tbl_ctl_o = '{en: 1'b1, we: 1'b1};
            end else if (!sp_ok_q || used_q == USED_MAX) begin
              res_status_d = tpt_pkg::STAT_NO_TABLE;
            end else begin
              dir_ctl_o   = '{en: 1'b1, we: 1'b1};
              dir_wdata_o = {1'b1, used_q[TW-1:0]};
              tbl_ctl_o   = '{en: 1'b1, we: 1'b1};
              tbl_addr_o  = {used_q[TW-1:0], ti_q};
              used_d      = used_q + UW'(1);
            end
          end
          tpt_pkg::OP_UNMAP: begin
            if (present) begin
              tbl_ctl_o = '{en: 1'b1, we: 1'b1};
            end
          end
          tpt_pkg::OP_TRANS: begin
            if (present) begin
              tbl_ctl_o.en = 1'b1;
              state_d      = tpt_pkg::ST_TBL;
            end else begin
              res_status_d = tpt_pkg::STAT_NOT_MAPPED;
            end
          end
          default: begin
          end
        endcase
      end
      tpt_pkg::ST_TBL: begin
        if (tbl_rdata_i[0]) begin
          res_phys_d = {tbl_rdata_i[31:12], ofs_q};
        end else begin
          res_status_d = tpt_pkg::STAT_NOT_MAPPED;
        end
        state_d = tpt_pkg::ST_DONE;
      end
      tpt_pkg::ST_DONE: begin
        if (!out_valid_q || take) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_phys_d   = res_phys_q;
          state_d      = tpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tpt_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpt_pkg::ST_CLEAR;
      clr_q       <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_phys_q   <= res_phys_d;
    out_status_q <= out_status_d;
    out_phys_q   <= out_phys_d;
    if (accept) begin
      op_q    <= opcode_i;
      sp_ok_q <= (32'(space_i) < NUM_SPACES);
      dslot_q <= in_dslot;
      ti_q    <= virt_addr_i[21:12];
      ofs_q   <= virt_addr_i[11:0];
      entry_q <= {phys_addr_i[31:12], page_flags_i | 12'h001};
    end
  end

endmodule

// File: design/two_level_page_table_top.sv
// Top level of the two-level page table engine.
// Sequence: IDLE issues the directory read; DIR acts on the entry; TBL (translate only)
// takes the table word; DONE loads the result register once no untaken result is held.
// in_stall_o is high from acceptance until then, so one request is in flight at a time.
// Reset: a sweep over max(NUM_SPACES, NUM_TABLES) * 1024 addresses zeroes both
// stores, with in_stall_o high until it ends.
module two_level_page_table_top #(
  parameter int NUM_SPACES = tpt_pkg::DEF_NUM_SPACES,
  parameter int NUM_TABLES = tpt_pkg::DEF_NUM_TABLES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [1:0]  space_i,
  input  logic [31:0] virt_addr_i,
  input  logic [31:0] phys_addr_i,
  input  logic [11:0] page_flags_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] phys_out_o
);

  localparam int TW  = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int DAW = $clog2(NUM_SPACES * 1024);
  localparam int TAW = TW + tpt_pkg::IDX_W;

  tpt_pkg::mem_ctl_t dir_ctl, tbl_ctl;
  logic [DAW-1:0]    dir_addr;
  logic [TW:0]       dir_wdata, dir_rdata;
  logic [TAW-1:0]    tbl_addr;
  logic [31:0]       tbl_wdata, tbl_rdata;

  tpt_ctrl #(
    .NUM_SPACES(NUM_SPACES),
    .NUM_TABLES(NUM_TABLES),
    .TW        (TW),
    .DAW       (DAW),
    .TAW       (TAW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .space_i     (space_i),
    .virt_addr_i (virt_addr_i),
    .phys_addr_i (phys_addr_i),
    .page_flags_i(page_flags_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .phys_out_o  (phys_out_o),
    .dir_ctl_o   (dir_ctl),
    .dir_addr_o  (dir_addr),
    .dir_wdata_o (dir_wdata),
    .dir_rdata_i (dir_rdata),
    .tbl_ctl_o   (tbl_ctl),
    .tbl_addr_o  (tbl_addr),
    .tbl_wdata_o (tbl_wdata),
    .tbl_rdata_i (tbl_rdata)
  );

  tpt_ram #(
    .DEPTH(NUM_SPACES * 1024),
    .WIDTH(TW + 1),
    .AW   (DAW)
  ) u_dir_ram (
    .clk_i  (clk_i),
    .ctl_i  (dir_ctl),
    .addr_i (dir_addr),
    .wdata_i(dir_wdata),
    .rdata_o(dir_rdata)
  );

  tpt_ram #(
    .DEPTH(NUM_TABLES * 1024),
    .WIDTH(32),
    .AW   (TAW)
  ) u_tbl_ram (
    .clk_i  (clk_i),
    .ctl_i  (tbl_ctl),
    .addr_i (tbl_addr),
    .wdata_i(tbl_wdata),
    .rdata_o(tbl_rdata)
  );

endmodule

// File: design/tpt_checker.sv
// Port-level assertions for the page table engine, bound to the top level.
module tpt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  opcode_i,
  input logic [1:0]  space_i,
  input logic [31:0] virt_addr_i,
  input logic [31:0] phys_addr_i,
  input logic [11:0] page_flags_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [31:0] phys_out_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("engine took a second request while busy");

  a_result_needs_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o) && $past(in_stall_o, 2))
    else $error("result appeared without a request in flight");

  a_phys_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (phys_out_o != 32'd0) |-> (status_o == tpt_pkg::STAT_OK))
    else $error("nonzero address with an error status");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(phys_out_o))
    else $error("stalled result changed");

endmodule

bind two_level_page_table_top tpt_checker u_tpt_checker (.*);

// File: test/tb_two_level_page_table_top.sv
// Self-checking testbench for the two-level page table engine: directed and random requests.
module tb_two_level_page_table_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SPACES  = tpt_pkg::DEF_NUM_SPACES;
  localparam int NUM_TABLES  = tpt_pkg::DEF_NUM_TABLES;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int HOT_DIRS    = 24;
  localparam int HOT_TBLS    = 8;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    tpt_pkg::status_e status;
    logic [31:0]      phys;
  } xlat_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = '0;
  logic [1:0]  space_i = '0;
  logic [31:0] virt_addr_i = '0;
  logic [31:0] phys_addr_i = '0;
  logic [11:0] page_flags_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] phys_out_o;

  bit          dir_present [NUM_SPACES*1024];
  int          dir_tnum    [NUM_SPACES*1024];
  logic [31:0] table_word  [NUM_TABLES*1024];
  int          tables_taken;

  xlat_result_t pending_results[$];
  bit          bursts_on = 1'b1;
  int          failures;
  int          cycles;
  int          n_requests;
  int          n_results;
  int          n_trans_hits;
  int          n_trans_misses;
  int          n_map_refused;

  bit          hot_ready;
  logic [1:0]  hot_space [HOT_DIRS];
  logic [9:0]  hot_dir   [HOT_DIRS];
  logic [9:0]  hot_tbl   [HOT_TBLS];

  two_level_page_table_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .space_i     (space_i),
    .virt_addr_i (virt_addr_i),
    .phys_addr_i (phys_addr_i),
    .page_flags_i(page_flags_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .phys_out_o  (phys_out_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void walk_page_table(input logic [1:0] op, input logic [1:0] sp,
                                          input logic [31:0] va, input logic [31:0] pa,
                                          input logic [11:0] fl, output xlat_result_t res);
    bit          sp_ok;
    bit          present;
    int          dslot;
    int          tnum;
    logic [31:0] word;
    sp_ok   = sp < NUM_SPACES;
    dslot   = sp_ok ? int'(sp) * 1024 + int'(va[31:22]) : 0;
    present = sp_ok && dir_present[dslot];
    tnum    = present ? dir_tnum[dslot] : 0;
    if (tnum >= NUM_TABLES) present = 1'b0;
    res.status = tpt_pkg::STAT_OK;
    res.phys   = '0;
    case (op)
      tpt_pkg::OP_MAP: begin
        if (!present) begin
          if (!sp_ok || tables_taken >= NUM_TABLES) begin
            res.status = tpt_pkg::STAT_NO_TABLE;
            n_map_refused++;
          end else begin
            tnum = tables_taken;
            tables_taken++;
            dir_present[dslot] = 1'b1;
            dir_tnum[dslot]    = tnum;
            present            = 1'b1;
          end
        end
        if (present) table_word[tnum*1024 + int'(va[21:12])] = {pa[31:12], fl} | 32'd1;
      end
      tpt_pkg::OP_UNMAP: begin
        if (present) table_word[tnum*1024 + int'(va[21:12])] = '0;
      end
      tpt_pkg::OP_TRANS: begin
        word = present ? table_word[tnum*1024 + int'(va[21:12])] : '0;
        if (present && word[0]) begin
          res.phys = {word[31:12], va[11:0]};
          n_trans_hits++;
        end else begin
          res.status = tpt_pkg::STAT_NOT_MAPPED;
          n_trans_misses++;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [1:0] sp,
                              input logic [31:0] va, input logic [31:0] pa,
                              input logic [11:0] fl);
    xlat_result_t res;
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    space_i      <= sp;
    virt_addr_i  <= va;
    phys_addr_i  <= pa;
    page_flags_i <= fl;
    do @(posedge clk_i); while (in_stall_o);
    walk_page_table(op, sp, va, pa, fl, res);
    pending_results.push_back(res);
    n_requests++;
  endtask

  task automatic pause_input();
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (bursts_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    xlat_result_t exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: status %0d phys_out %h", status_o, phys_out_o);
        failures++;
      end else begin
        exp = pending_results.pop_front();
        if (status_o !== exp.status) begin
          $error("status: expected %0d, actual %0d", exp.status, status_o);
          failures++;
        end
        if (phys_out_o !== exp.phys) begin
          $error("phys_out: expected %h, actual %h", exp.phys, phys_out_o);
          failures++;
        end
      end
    end
  end

  task automatic test_map_translate();
    pause_input();
    send_request(tpt_pkg::OP_MAP, 2'd0, 32'h0000_0000, 32'hFFFF_FFFF, 12'h000);
    pause_input();
    send_request(tpt_pkg::OP_TRANS, 2'd0, 32'h0000_0FFF, 32'hFFFF_FFFF, 12'hFFF);
    send_request(tpt_pkg::OP_MAP, 2'd3, 32'hFFFF_FFFF, 32'h0000_0000, 12'hFFF);
    pause_input();
    send_request(tpt_pkg::OP_TRANS, 2'd3, 32'hFFFF_F000, 32'h0, 12'h0);
    send_request(tpt_pkg::OP_TRANS, 2'd2, 32'hFFFF_F000, 32'h0, 12'h0);
    send_request(tpt_pkg::OP_MAP, 2'd0, 32'h0000_5ABC, 32'h1234_5FFF, 12'hA5A);
    send_request(tpt_pkg::OP_TRANS, 2'd0, 32'h0000_5123, 32'h0, 12'h0);
    send_request(tpt_pkg::OP_TRANS, 2'd0, 32'h0000_6000, 32'h0, 12'h0);
  endtask

  task automatic test_remap_unmap();
    send_request(tpt_pkg::OP_MAP, 2'd0, 32'h0000_5000, 32'h8765_4000, 12'h5A4);
    pause_input();
    send_request(tpt_pkg::OP_TRANS, 2'd0, 32'h0000_5FFF, 32'h0, 12'h0);
    send_request(tpt_pkg::OP_UNMAP, 2'd1, 32'h1234_5678, 32'hFFFF_FFFF, 12'hFFF);
    send_request(tpt_pkg::OP_UNMAP, 2'd0, 32'h0000_0000, 32'h0, 12'h0);
    pause_input();
    send_request(tpt_pkg::OP_TRANS, 2'd0, 32'h0000_0000, 32'h0, 12'h0);
    send_request(tpt_pkg::OP_UNMAP, 2'd0, 32'h0000_0000, 32'h0, 12'h0);
    send_request(tpt_pkg::OP_TRANS, 2'd1, 32'h1234_5678, 32'h0, 12'h0);
  endtask

  task automatic test_unused_opcode();
    send_request(OP_UNUSED, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    pause_input();
    send_request(OP_UNUSED, 2'd0, 32'h0000_0000, 32'h0000_0000, 12'h000);
    send_request(tpt_pkg::OP_TRANS, 2'd3, 32'hFFFF_FFFF, 32'h0, 12'h0);
  endtask

  task automatic test_random_traffic(input int count);
    int          k;
    int          pick;
    int          roll;
    logic [1:0]  op;
    logic [1:0]  sp;
    logic [31:0] va;
    if (!hot_ready) begin
      for (k = 0; k < HOT_DIRS; k++) begin
        hot_space[k] = 2'($urandom_range(0, 3));
        hot_dir[k]   = 10'($urandom);
      end
      for (k = 0; k < HOT_TBLS; k++) hot_tbl[k] = 10'($urandom);
      hot_ready = 1'b1;
    end
    for (k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) op = tpt_pkg::OP_MAP;
      else if (roll < 50) op = tpt_pkg::OP_UNMAP;
      else if (roll < 95) op = tpt_pkg::OP_TRANS;
      else op = OP_UNUSED;
      if ($urandom_range(0, 9) == 0) begin
        sp = 2'($urandom);
        va = $urandom;
      end else begin
        pick = $urandom_range(0, HOT_DIRS - 1);
        sp   = hot_space[pick];
        va   = {hot_dir[pick], hot_tbl[$urandom_range(0, HOT_TBLS - 1)], 12'($urandom)};
      end
      pause_input();
      send_request(op, sp, va, $urandom, 12'($urandom));
    end
  endtask

  task automatic test_pool_exhaustion();
    int         refused;
    int         d;
    logic [1:0] sp;
    refused = 0;
    while (refused < 3) begin
      do begin
        sp = 2'($urandom);
        d  = $urandom_range(0, 1023);
      end while (dir_present[int'(sp)*1024 + d]);
      if (tables_taken >= NUM_TABLES) refused++;
      pause_input();
      send_request(tpt_pkg::OP_MAP, sp, {10'(d), 22'($urandom)}, $urandom, 12'($urandom));
    end
    do begin
      sp = 2'($urandom);
      d  = $urandom_range(0, 1023);
    end while (!dir_present[int'(sp)*1024 + d]);
    send_request(tpt_pkg::OP_MAP, sp, {10'(d), 10'h3FF, 12'h0}, $urandom, 12'($urandom));
    send_request(tpt_pkg::OP_TRANS, sp, {10'(d), 10'h3FF, 12'($urandom)}, 32'h0, 12'h0);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_map_translate();
    test_remap_unmap();
    test_unused_opcode();
    test_random_traffic(450);
    test_pool_exhaustion();
    bursts_on = 1'b0;
    test_random_traffic(150);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    $display("%0d requests, %0d results; %0d translate hits, %0d misses, %0d maps refused",
             n_requests, n_results, n_trans_hits, n_trans_misses, n_map_refused);
    $display("%0d of %0d page tables taken, %0d mismatches", tables_taken, NUM_TABLES,
             failures);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
